>>> rtl/camray_pkg.sv
// Shared types and constants for the camera ray direction block.
package camray_pkg;

  localparam int SCREEN_W   = 13;
  localparam int FOV_W      = 14;
  localparam int YAW_W      = 16;
  localparam int PITCH_W    = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int OUT_W      = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FOV           = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_YAW           = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PITCH         = 3'd4;

  localparam logic [SCREEN_W-1:0] RST_SCREEN_WIDTH  = 13'd1920;
  localparam logic [SCREEN_W-1:0] RST_SCREEN_HEIGHT = 13'd1080;
  localparam logic [FOV_W-1:0]    RST_FOV           = 14'd4500;

  // Q2.30 fixed point
  localparam int Q_BITS = 30;
  localparam int Q30_W  = 32;
  localparam int M_W    = 30;
  typedef logic signed [Q30_W-1:0] q30_t;

  // CORDIC, angles in 1/4096 centidegree
  localparam int CORDIC_STEPS = 20;
  localparam int STEP_W       = 5;
  localparam int ANG_W        = 29;
  localparam int ATAN_W       = 25;
  localparam logic signed [ANG_W-1:0] ANG_FULL    = 29'sd147456000;
  localparam logic signed [ANG_W-1:0] ANG_HALF    = 29'sd73728000;
  localparam logic signed [ANG_W-1:0] ANG_QUARTER = 29'sd36864000;
  localparam q30_t CORDIC_GAIN = 32'sd652032874;
  localparam logic [ATAN_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    25'd18432000, 25'd10881045, 25'd5749245, 25'd2918407, 25'd1464867,
    25'd733147, 25'd366663, 25'd183343, 25'd91673, 25'd45837,
    25'd22918, 25'd11459, 25'd5730, 25'd2865, 25'd1432,
    25'd716, 25'd358, 25'd179, 25'd90, 25'd45
  };

  localparam int SQRT_STEPS = 32;
  localparam int SQ_W       = 64;

  localparam logic signed [OUT_W-1:0] OUT_MAX = 16'sh7fff;
  localparam logic signed [OUT_W-1:0] OUT_MIN = 16'sh8000;

endpackage

>>> rtl/camray_norm.sv
// Pipelined 3-vector normalizer: scale, sum of squares, square root, divide.
module camray_norm
  import camray_pkg::*;
#(
  parameter int IW = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [IW-1:0] in_vec [3],
  output logic                 out_valid,
  output q30_t                 out_vec [3]
);

  localparam int NG    = (IW + 7) / 8;
  localparam int GW    = $clog2(NG);
  localparam int BLW   = $clog2(NG * 8 + 1);
  localparam int NW    = Q_BITS + 1;
  localparam int QW    = Q_BITS + 1;
  localparam int DVW   = 2 * Q_BITS + 2;
  localparam int DIV_STEPS = Q_BITS + 1;

  // s1: magnitudes
  logic          v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic [IW-1:0] mag1_r [3], mag2_r [3], mag3_r [3], mag4_r [3];
  logic [2:0]    neg1_r, neg2_r, neg3_r, neg4_r, neg5_r, neg6_r;
  logic [IW-1:0] top;
  logic [NG*8-1:0] pad;
  logic [GW-1:0] grp, grp3_r;
  logic [7:0]    grp_bits, grp_bits3_r;
  logic          zero3_r, zero4_r, zero5_r, zero6_r;
  logic [3:0]    blen;
  logic [BLW-1:0] bl, sr, sl, sr4_r, sl4_r;
  logic [M_W-1:0] m5_r [3], m6_r [3];
  logic [2*M_W-1:0] sq6_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0;
      v4_r <= 1'b0; v5_r <= 1'b0; v6_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid; v2_r <= v1_r; v3_r <= v2_r;
      v4_r <= v3_r; v5_r <= v4_r; v6_r <= v5_r;
    end
  end

  always_comb begin
    top = mag2_r[0];
    if (mag2_r[1] > top) top = mag2_r[1];
    if (mag2_r[2] > top) top = mag2_r[2];
  end

  always_comb begin
    pad = (NG*8)'(top);
    grp = '0;
    for (int g = 0; g < NG; g++) begin
      if (pad[g*8 +: 8] != 8'd0) grp = GW'(g);
    end
    grp_bits = pad[grp*8 +: 8];
  end

  always_comb begin
    blen = 4'd0;
    for (int b = 0; b < 8; b++) begin
      if (grp_bits3_r[b]) blen = 4'(b + 1);
    end
    bl = BLW'({grp3_r, 3'b000}) + BLW'(blen);
    sr = (bl > BLW'(Q_BITS)) ? bl - BLW'(Q_BITS) : '0;
    sl = (bl < BLW'(Q_BITS)) ? BLW'(Q_BITS) - bl : '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mag1_r[i] <= in_vec[i][IW-1] ? IW'(-in_vec[i]) : IW'(in_vec[i]);
        neg1_r[i] <= in_vec[i][IW-1];
      end
      mag2_r <= mag1_r; neg2_r <= neg1_r;
      mag3_r <= mag2_r; neg3_r <= neg2_r;
      grp3_r <= grp; grp_bits3_r <= grp_bits;
      zero3_r <= (top == '0);
      mag4_r <= mag3_r; neg4_r <= neg3_r; zero4_r <= zero3_r;
      sr4_r <= sr; sl4_r <= sl;
      for (int i = 0; i < 3; i++) begin
        m5_r[i] <= M_W'((mag4_r[i] >> sr4_r) << sl4_r);
      end
      neg5_r <= neg4_r; zero5_r <= zero4_r;
      for (int i = 0; i < 3; i++) begin
        sq6_r[i] <= m5_r[i] * m5_r[i];
      end
      m6_r <= m5_r; neg6_r <= neg5_r; zero6_r <= zero5_r;
    end
  end

  // square root, one result bit per stage
  logic [SQ_W-1:0] sq_n_r [SQRT_STEPS+1];
  logic [SQ_W-1:0] sq_q_r [SQRT_STEPS+1];
  logic [M_W-1:0]  sq_m_r [SQRT_STEPS+1][3];
  logic [2:0]      sq_neg_r [SQRT_STEPS+1];
  logic            sq_zero_r [SQRT_STEPS+1];
  logic            sq_v_r [SQRT_STEPS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) sq_v_r[0] <= 1'b0;
    else if (en) sq_v_r[0] <= v6_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_n_r[0]    <= SQ_W'(sq6_r[0]) + SQ_W'(sq6_r[1]) + SQ_W'(sq6_r[2]);
      sq_q_r[0]    <= '0;
      sq_m_r[0]    <= m6_r;
      sq_neg_r[0]  <= neg6_r;
      sq_zero_r[0] <= zero6_r;
    end
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQRT_STEPS - 1 - k));
    logic [SQ_W-1:0] trial, n_nxt, q_nxt;
    always_comb begin
      trial = sq_q_r[k] + BIT;
      if (sq_n_r[k] >= trial) begin
        n_nxt = sq_n_r[k] - trial;
        q_nxt = (sq_q_r[k] >> 1) + BIT;
      end else begin
        n_nxt = sq_n_r[k];
        q_nxt = sq_q_r[k] >> 1;
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) sq_v_r[k+1] <= 1'b0;
      else if (en) sq_v_r[k+1] <= sq_v_r[k];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sq_n_r[k+1]    <= n_nxt;
        sq_q_r[k+1]    <= q_nxt;
        sq_m_r[k+1]    <= sq_m_r[k];
        sq_neg_r[k+1]  <= sq_neg_r[k];
        sq_zero_r[k+1] <= sq_zero_r[k];
      end
    end
  end

  // restoring divide, one quotient bit per stage
  logic [DVW-1:0] dv_rem_r [DIV_STEPS+1][3];
  logic [QW-1:0]  dv_q_r [DIV_STEPS+1][3];
  logic [NW-1:0]  dv_norm_r [DIV_STEPS+1];
  logic [2:0]     dv_neg_r [DIV_STEPS+1];
  logic           dv_zero_r [DIV_STEPS+1];
  logic           dv_v_r [DIV_STEPS+1];
  logic [NW-1:0]  root;

  assign root = NW'(sq_q_r[SQRT_STEPS]);

  always_ff @(posedge clk) begin
    if (!rst_n) dv_v_r[0] <= 1'b0;
    else if (en) dv_v_r[0] <= sq_v_r[SQRT_STEPS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dv_rem_r[0][i] <= DVW'({sq_m_r[SQRT_STEPS][i], {Q_BITS{1'b0}}}) + DVW'(root >> 1);
        dv_q_r[0][i]   <= '0;
      end
      dv_norm_r[0] <= root;
      dv_neg_r[0]  <= sq_neg_r[SQRT_STEPS];
      dv_zero_r[0] <= sq_zero_r[SQRT_STEPS];
    end
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    localparam int SHIFT = DIV_STEPS - 1 - j;
    logic [DVW-1:0] dsr;
    logic [DVW-1:0] rem_nxt [3];
    logic [QW-1:0]  q_nxt [3];
    always_comb begin
      dsr = DVW'(dv_norm_r[j]) << SHIFT;
      for (int i = 0; i < 3; i++) begin
        if (dv_rem_r[j][i] >= dsr) begin
          rem_nxt[i] = dv_rem_r[j][i] - dsr;
          q_nxt[i]   = dv_q_r[j][i] | (QW'(1) << SHIFT);
        end else begin
          rem_nxt[i] = dv_rem_r[j][i];
          q_nxt[i]   = dv_q_r[j][i];
        end
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) dv_v_r[j+1] <= 1'b0;
      else if (en) dv_v_r[j+1] <= dv_v_r[j];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv_rem_r[j+1]  <= rem_nxt;
        dv_q_r[j+1]    <= q_nxt;
        dv_norm_r[j+1] <= dv_norm_r[j];
        dv_neg_r[j+1]  <= dv_neg_r[j];
        dv_zero_r[j+1] <= dv_zero_r[j];
      end
    end
  end

  logic fv_r;
  q30_t fo_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) fv_r <= 1'b0;
    else if (en) fv_r <= dv_v_r[DIV_STEPS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (dv_zero_r[DIV_STEPS]) begin
          fo_r[i] <= '0;
        end else if (dv_neg_r[DIV_STEPS][i]) begin
          fo_r[i] <= -$signed({1'b0, dv_q_r[DIV_STEPS][i]});
        end else begin
          fo_r[i] <= $signed({1'b0, dv_q_r[DIV_STEPS][i]});
        end
      end
    end
  end

  assign out_valid = fv_r;
  assign out_vec   = fo_r;

endmodule

>>> rtl/camera_ray_direction_unit.sv
// Top level of the pinhole camera ray direction unit.
//
// Usage: one pixel coordinate in (in_pixel_x, in_pixel_y) per transaction on
// the in_ channel; one unit ray (out_ray_x/y/z, Q1.15, saturated) per
// transaction on the out_ channel, in the same order.
// Configuration (screen size, field of view, yaw, pitch) is written through
// cfg_we/cfg_index/cfg_data while no transaction is in flight.
// Every write, and reset, starts a sequential trig setup: one shared CORDIC
// runs 20 steps for each of the three angles, then four coefficient products
// are formed on one shared multiplier; in_ready stays low until it completes.
// Pipeline: 149 register stages: two input stages, two 72-stage normalizers
// (bit-serial square root and divide, one bit per stage), two rotation stages
// and the output register.
// Throughput: one pixel per cycle, limited by out_ready and by the trig setup.
// When the receiver stalls, the output register holds and the whole pipeline
// freezes with it; nothing is dropped or repeated.
// Reset (synchronous, active low) restores default configuration and clears
// all valid bits.
module camera_ray_direction_unit
  import camray_pkg::*;
#(
  parameter int PIXEL_BITS    = 12,
  parameter int FRACTION_BITS = 15
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [PIXEL_BITS-1:0]        in_pixel_x,
  input  logic [PIXEL_BITS-1:0]        in_pixel_y,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [OUT_W-1:0]      out_ray_x,
  output logic signed [OUT_W-1:0]      out_ray_y,
  output logic signed [OUT_W-1:0]      out_ray_z,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data
);

  localparam int PW = (PIXEL_BITS > SCREEN_W) ? PIXEL_BITS : SCREEN_W;
  localparam int DW = PW + 2;
  localparam int CW = Q30_W + DW;
  localparam int SH = Q_BITS - FRACTION_BITS;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LOAD  = 3'd1;
  localparam logic [2:0] ST_ITER  = 3'd2;
  localparam logic [2:0] ST_STORE = 3'd3;
  localparam logic [2:0] ST_MUL   = 3'd4;
  localparam logic [2:0] ST_RND   = 3'd5;

  localparam logic [1:0] ANG_FOV   = 2'd0;
  localparam logic [1:0] ANG_YAW   = 2'd1;
  localparam logic [1:0] ANG_PITCH = 2'd2;

  // configuration
  logic [SCREEN_W-1:0]      scr_w_r, scr_h_r;
  logic [FOV_W-1:0]         fov_r;
  logic signed [YAW_W-1:0]  yaw_r;
  logic signed [PITCH_W-1:0] pitch_r;

  // trig setup sequencer
  logic [2:0]        st_r;
  logic [1:0]        sel_r;
  logic [STEP_W-1:0] step_r;
  logic [1:0]        mi_r;
  q30_t              cx_r, cy_r;
  logic signed [ANG_W-1:0] cr_r;
  logic              neg_r;
  q30_t ch_r, shh_r, cb_r, sb_r, cc_r, sc_r;
  q30_t sbsc_r, sbcc_r, cbsc_r, cbcc_r;
  logic signed [SQ_W-1:0] prod_r;

  logic signed [ANG_W-1:0] ang_raw, ang_wrap, ang_fold, atan;
  logic fold_neg;
  q30_t dx, dy, cf, sf, pa, pb, rnd_q, rnd_val;
  logic [SQ_W-1:0] pmag, rsum;

  always_comb begin
    unique case (sel_r)
      ANG_FOV:   ang_raw = $signed({4'b0000, fov_r, 11'b0});
      ANG_YAW:   ang_raw = $signed({yaw_r[YAW_W-1], yaw_r, 12'b0});
      ANG_PITCH: ang_raw = $signed({{2{pitch_r[PITCH_W-1]}}, pitch_r, 12'b0});
      default:   ang_raw = '0;
    endcase
    if (ang_raw >= ANG_HALF) ang_wrap = ang_raw - ANG_FULL;
    else if (ang_raw < -ANG_HALF) ang_wrap = ang_raw + ANG_FULL;
    else ang_wrap = ang_raw;
    fold_neg = 1'b1;
    if (ang_wrap > ANG_QUARTER) ang_fold = ang_wrap - ANG_HALF;
    else if (ang_wrap < -ANG_QUARTER) ang_fold = ang_wrap + ANG_HALF;
    else begin
      ang_fold = ang_wrap;
      fold_neg = 1'b0;
    end
  end

  always_comb begin
    dx   = cy_r >>> step_r;
    dy   = cx_r >>> step_r;
    atan = $signed(ANG_W'(ATAN_TAB[step_r]));
    cf   = neg_r ? -cx_r : cx_r;
    sf   = neg_r ? -cy_r : cy_r;
    pa   = mi_r[1] ? cb_r : sb_r;
    pb   = mi_r[0] ? cc_r : sc_r;
    pmag = prod_r[SQ_W-1] ? SQ_W'(-prod_r) : SQ_W'(prod_r);
    rsum = pmag + (SQ_W'(1) << (Q_BITS - 1));
    rnd_q = q30_t'(rsum >> Q_BITS);
    rnd_val = prod_r[SQ_W-1] ? -rnd_q : rnd_q;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_w_r <= RST_SCREEN_WIDTH;
      scr_h_r <= RST_SCREEN_HEIGHT;
      fov_r   <= RST_FOV;
      yaw_r   <= '0;
      pitch_r <= '0;
      st_r    <= ST_LOAD;
      sel_r   <= ANG_FOV;
      step_r  <= '0;
      mi_r    <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SCREEN_WIDTH:  scr_w_r <= cfg_data[SCREEN_W-1:0];
          CFG_SCREEN_HEIGHT: scr_h_r <= cfg_data[SCREEN_W-1:0];
          CFG_FOV:           fov_r   <= cfg_data[FOV_W-1:0];
          CFG_YAW:           yaw_r   <= $signed(cfg_data[YAW_W-1:0]);
          CFG_PITCH:         pitch_r <= $signed(cfg_data[PITCH_W-1:0]);
          default: ;
        endcase
        st_r  <= ST_LOAD;
        sel_r <= ANG_FOV;
      end else begin
        unique case (st_r)
          ST_IDLE: ;
          ST_LOAD: begin
            step_r <= '0;
            st_r   <= ST_ITER;
          end
          ST_ITER: begin
            if (step_r == STEP_W'(CORDIC_STEPS - 1)) st_r <= ST_STORE;
            else step_r <= step_r + 1'b1;
          end
          ST_STORE: begin
            if (sel_r == ANG_PITCH) begin
              mi_r <= '0;
              st_r <= ST_MUL;
            end else begin
              sel_r <= sel_r + 2'd1;
              st_r  <= ST_LOAD;
            end
          end
          ST_MUL: st_r <= ST_RND;
          ST_RND: begin
            if (mi_r == 2'd3) st_r <= ST_IDLE;
            else begin
              mi_r <= mi_r + 2'd1;
              st_r <= ST_MUL;
            end
          end
          default: st_r <= ST_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      ST_LOAD: begin
        cx_r  <= CORDIC_GAIN;
        cy_r  <= '0;
        cr_r  <= ang_fold;
        neg_r <= fold_neg;
      end
      ST_ITER: begin
        if (cr_r >= 0) begin
          cx_r <= cx_r - dx;
          cy_r <= cy_r + dy;
          cr_r <= cr_r - atan;
        end else begin
          cx_r <= cx_r + dx;
          cy_r <= cy_r - dy;
          cr_r <= cr_r + atan;
        end
      end
      ST_STORE: begin
        unique case (sel_r)
          ANG_FOV: begin
            ch_r  <= cf;
            shh_r <= sf;
          end
          ANG_YAW: begin
            cb_r <= cf;
            sb_r <= sf;
          end
          ANG_PITCH: begin
            cc_r <= cf;
            sc_r <= -sf;
          end
          default: ;
        endcase
      end
      ST_MUL: prod_r <= pa * pb;
      ST_RND: begin
        unique case (mi_r)
          2'd0: sbsc_r <= rnd_val;
          2'd1: sbcc_r <= rnd_val;
          2'd2: cbsc_r <= rnd_val;
          2'd3: cbcc_r <= rnd_val;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // pixel pipeline
  logic en, acc;
  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic signed [DW-1:0] dx_r, dy_r;
  logic signed [CW-1:0] cam_r [3];
  q30_t u_vec [3], fin_vec [3];
  logic nv1, nv2;
  logic signed [SQ_W-1:0] prd_r [8];
  logic signed [SQ_W-1:0] rot_r [3];
  logic signed [OUT_W-1:0] ray_x_r, ray_y_r, ray_z_r;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en && (st_r == ST_IDLE);
  assign acc      = in_valid && in_ready;

  function automatic logic signed [OUT_W-1:0] to_out(input q30_t v);
    logic [Q30_W-1:0] m;
    logic [Q30_W-1:0] r;
    m = v[Q30_W-1] ? Q30_W'(-v) : Q30_W'(v);
    r = (m + (Q30_W'(1) << (SH - 1))) >> SH;
    if (!v[Q30_W-1]) begin
      to_out = (r > Q30_W'(32767)) ? OUT_MAX : $signed(OUT_W'(r));
    end else begin
      to_out = (r > Q30_W'(32768)) ? OUT_MIN : -$signed(OUT_W'(r));
    end
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r <= acc;
      v2_r <= v1_r;
      v3_r <= nv1;
      v4_r <= v3_r;
      out_valid_r <= nv2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r <= $signed(DW'({in_pixel_x, 1'b0})) - $signed(DW'(scr_w_r));
      dy_r <= $signed(DW'(scr_h_r)) - $signed(DW'({in_pixel_y, 1'b0}));
      cam_r[0] <= shh_r * dx_r;
      cam_r[1] <= shh_r * dy_r;
      cam_r[2] <= ch_r * $signed({1'b0, scr_h_r});
      prd_r[0] <= u_vec[0] * cb_r;
      prd_r[1] <= u_vec[1] * sbsc_r;
      prd_r[2] <= u_vec[2] * sbcc_r;
      prd_r[3] <= u_vec[1] * cc_r;
      prd_r[4] <= u_vec[2] * sc_r;
      prd_r[5] <= u_vec[0] * sb_r;
      prd_r[6] <= u_vec[1] * cbsc_r;
      prd_r[7] <= u_vec[2] * cbcc_r;
      // rotated vector stored with first and third swapped
      rot_r[2] <= prd_r[0] + prd_r[1] + prd_r[2];
      rot_r[1] <= prd_r[3] - prd_r[4];
      rot_r[0] <= prd_r[6] + prd_r[7] - prd_r[5];
      ray_x_r <= to_out(fin_vec[0]);
      ray_y_r <= to_out(fin_vec[1]);
      ray_z_r <= to_out(fin_vec[2]);
    end
  end

  camray_norm #(.IW(CW)) u_norm_cam (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v2_r),
    .in_vec    (cam_r),
    .out_valid (nv1),
    .out_vec   (u_vec)
  );

  camray_norm #(.IW(SQ_W)) u_norm_rot (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v4_r),
    .in_vec    (rot_r),
    .out_valid (nv2),
    .out_vec   (fin_vec)
  );

  assign out_valid = out_valid_r;
  assign out_ray_x = ray_x_r;
  assign out_ray_y = ray_y_r;
  assign out_ray_z = ray_z_r;

`ifndef ASSERT_OFF
  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_ready)
    else $error("input accepted right after a configuration write");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_ITER |-> step_r < STEP_W'(CORDIC_STEPS))
    else $error("CORDIC step out of range");

  a_coef_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_IDLE && $past(st_r == ST_IDLE))
      |-> ($stable(shh_r) && $stable(sbsc_r) && $stable(cbcc_r)))
    else $error("coefficients changed while idle");
`endif

endmodule
